// ===== rtl/ssa_pkg.sv =====
// Shared types and constants for the shadow slot allocator.
package ssa_pkg;

  localparam int SLOTS  = 8;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TAG_W  = 16;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 3;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // search token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              hit_found;
    logic [IDX_W-1:0]  hit_idx;
    logic [TIME_W-1:0] hit_time;
    logic              empty_found;
    logic [IDX_W-1:0]  empty_idx;
    logic [IDX_W-1:0]  lru_idx;
    logic [TIME_W-1:0] lru_time;
  } scan_t;

  // slot update broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic              set_tag;
    logic              set_time;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] now;
  } wr_t;

endpackage

// ===== rtl/shadow_slot_allocator_unit.sv =====
// Top level: request capture, cell chain, slot choice and result register.
//
//   channel | direction | ports                                   | handshake
//   in      | input     | in_light_id, in_last_change_time, in_now_time | in_valid / in_ready
//   out     | output    | out_slot, out_render_needed, out_hit, out_replaced | out_valid / out_ready
//   cfg     | input     | cfg_wdata (slots_in_use)                | cfg_we, no wait
//
// One request at a time: the accepted request is registered, passes each cell of the chain
// in turn, is captured in the result register and then updates its slot; no new accept before that.
// in_ready rises again once the slot update is done; the result may still sit
// in the output register, and a stalled out_ready only delays the update step.
// rst_n is synchronous: all slots empty, slots_in_use = 8.
module shadow_slot_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ssa_pkg::TAG_W-1:0]     in_light_id,
  input  logic [ssa_pkg::TIME_W-1:0]    in_last_change_time,
  input  logic [ssa_pkg::TIME_W-1:0]    in_now_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssa_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_render_needed,
  output logic                          out_hit,
  output logic                          out_replaced,
  input  logic                          cfg_we,
  input  logic [ssa_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [ssa_pkg::CFG_W-1:0]    cfg_r;
  logic [ssa_pkg::CNT_W-1:0]    active_n;
  logic                         inject_r;
  logic [ssa_pkg::TAG_W-1:0]    tag_r;
  logic [ssa_pkg::TIME_W-1:0]   change_r;
  logic [ssa_pkg::TIME_W-1:0]   now_r;
  ssa_pkg::scan_t               res_r;
  ssa_pkg::scan_t               chain [ssa_pkg::SLOTS+1];
  logic [ssa_pkg::SLOTS-1:0]    chain_vld;
  ssa_pkg::wr_t                 wr;

  logic                         out_valid_r;
  logic [ssa_pkg::SLOT_W-1:0]   out_slot_r;
  logic                         out_render_r;
  logic                         out_hit_r;
  logic                         out_replaced_r;

  logic                         in_beat;
  logic                         out_free;
  logic                         finish;
  logic [ssa_pkg::IDX_W-1:0]    pick;
  logic                         render;

  assign in_ready = (state_r == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign finish   = (state_r == S_DONE) && out_free;

  // slots_in_use clamped to 1..SLOTS
  always_comb begin
    if (cfg_r == '0) begin
      active_n = ssa_pkg::CNT_W'(1);
    end else if (int'(cfg_r) > ssa_pkg::SLOTS) begin
      active_n = ssa_pkg::CNT_W'(ssa_pkg::SLOTS);
    end else begin
      active_n = ssa_pkg::CNT_W'(cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ssa_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    chain[0]     = '0;
    chain[0].vld = inject_r;
  end

  for (genvar g = 0; g < ssa_pkg::SLOTS; g++) begin : g_cell
    ssa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (ssa_pkg::IDX_W'(g)),
      .active_n (active_n),
      .tag      (tag_r),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1]),
      .wr       (wr)
    );
    assign chain_vld[g] = chain[g+1].vld;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_beat) state_nxt = S_SCAN;
      S_SCAN: if (chain[ssa_pkg::SLOTS].vld) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      inject_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inject_r <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      tag_r    <= in_light_id;
      change_r <= in_last_change_time;
      now_r    <= in_now_time;
    end
    if (chain[ssa_pkg::SLOTS].vld) begin
      res_r <= chain[ssa_pkg::SLOTS];
    end
  end

  // hit first, then lowest empty slot, then least recently rendered
  always_comb begin
    if (res_r.hit_found) begin
      pick   = res_r.hit_idx;
      render = change_r >= res_r.hit_time;
    end else if (res_r.empty_found) begin
      pick   = res_r.empty_idx;
      render = 1'b1;
    end else begin
      pick   = res_r.lru_idx;
      render = 1'b1;
    end
  end

  always_comb begin
    wr.en       = finish;
    wr.idx      = pick;
    wr.set_tag  = !res_r.hit_found;
    wr.set_time = render;
    wr.tag      = tag_r;
    wr.now      = now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_slot_r     <= ssa_pkg::SLOT_W'(pick);
      out_render_r   <= render;
      out_hit_r      <= res_r.hit_found;
      out_replaced_r <= !res_r.hit_found && !res_r.empty_found;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slot          = out_slot_r;
  assign out_render_needed = out_render_r;
  assign out_hit           = out_hit_r;
  assign out_replaced      = out_replaced_r;

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({inject_r, chain_vld}))
    else $error("more than one search token in the chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (chain_vld == '0) && !inject_r)
    else $error("search token in flight while idle");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_DONE) && !$past(inject_r))
    else $error("slot update outside the done step");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("slot update without a result");
`endif

endmodule

// ===== rtl/ssa_cell.sv =====
// One slot cell: holds valid, tag and time, and folds itself into the passing search token.
module ssa_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ssa_pkg::IDX_W-1:0]  cell_idx,
  input  logic [ssa_pkg::CNT_W-1:0]  active_n,
  input  logic [ssa_pkg::TAG_W-1:0]  tag,
  input  ssa_pkg::scan_t             tok_in,
  output ssa_pkg::scan_t             tok_out,
  input  ssa_pkg::wr_t               wr
);

  logic                        valid_r;
  logic [ssa_pkg::TAG_W-1:0]   light_r;
  logic [ssa_pkg::TIME_W-1:0]  time_r;
  ssa_pkg::scan_t              tok_r;
  ssa_pkg::scan_t              tok_nxt;
  logic                        active;
  logic                        sel;

  assign active = ssa_pkg::CNT_W'(cell_idx) < active_n;
  assign sel    = wr.en && (wr.idx == cell_idx);

  always_comb begin
    tok_nxt = tok_in;
    if (active) begin
      if (valid_r && (light_r == tag) && !tok_in.hit_found) begin
        tok_nxt.hit_found = 1'b1;
        tok_nxt.hit_idx   = cell_idx;
        tok_nxt.hit_time  = time_r;
      end
      if (!valid_r && !tok_in.empty_found) begin
        tok_nxt.empty_found = 1'b1;
        tok_nxt.empty_idx   = cell_idx;
      end
      // strict less keeps the lowest index on ties
      if ((cell_idx == '0) || (time_r < tok_in.lru_time)) begin
        tok_nxt.lru_idx  = cell_idx;
        tok_nxt.lru_time = time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.hit_found   <= tok_nxt.hit_found;
    tok_r.hit_idx     <= tok_nxt.hit_idx;
    tok_r.hit_time    <= tok_nxt.hit_time;
    tok_r.empty_found <= tok_nxt.empty_found;
    tok_r.empty_idx   <= tok_nxt.empty_idx;
    tok_r.lru_idx     <= tok_nxt.lru_idx;
    tok_r.lru_time    <= tok_nxt.lru_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      time_r  <= '0;
    end else if (sel) begin
      if (wr.set_tag) begin
        valid_r <= 1'b1;
      end
      if (wr.set_time) begin
        time_r <= wr.now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.set_tag) begin
      light_r <= wr.tag;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== tb/shadow_slot_allocator_unit_tb.sv =====
// Self-checking testbench for shadow_slot_allocator_unit: slot choice, render flag and config sweep.
`timescale 1ns / 100ps

module shadow_slot_allocator_unit_tb;

  localparam int DRAIN_CYCLES = ssa_pkg::SLOTS + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int POOL         = 12;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 40;
  localparam int LIMIT_NS     = 5_000_000;
  localparam int MAX_PRINTS   = 40;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [ssa_pkg::TAG_W-1:0]  light;
    logic [ssa_pkg::TIME_W-1:0] change;
    logic [ssa_pkg::TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [ssa_pkg::SLOT_W-1:0] slot;
    logic                       render;
    logic                       hit;
    logic                       replaced;
  } slot_res_t;

  logic                         clk;
  logic                         rst_n               = 1'b0;
  logic                         in_valid            = 1'b0;
  logic                         in_ready;
  logic [ssa_pkg::TAG_W-1:0]    in_light_id         = '0;
  logic [ssa_pkg::TIME_W-1:0]   in_last_change_time = '0;
  logic [ssa_pkg::TIME_W-1:0]   in_now_time         = '0;
  logic                         out_valid;
  logic                         out_ready           = 1'b0;
  logic [ssa_pkg::SLOT_W-1:0]   out_slot;
  logic                         out_render_needed;
  logic                         out_hit;
  logic                         out_replaced;
  logic                         cfg_we              = 1'b0;
  logic [ssa_pkg::CFG_W-1:0]    cfg_wdata           = '0;

  // predictor copy of the slot table and the slot count register
  logic                         tbl_valid [ssa_pkg::SLOTS];
  logic [ssa_pkg::TAG_W-1:0]    tbl_light [ssa_pkg::SLOTS];
  logic [ssa_pkg::TIME_W-1:0]   tbl_time  [ssa_pkg::SLOTS];
  logic [ssa_pkg::CFG_W-1:0]    cfg_slots = ssa_pkg::CFG_RESET;

  req_t                         pend_q[$];
  slot_res_t                    alloc_q[$];
  req_t                         cur_req;
  logic [ssa_pkg::TAG_W-1:0]    light_pool [POOL];
  logic [ssa_pkg::TIME_W-1:0]   time_base;

  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  logic                hold_go        = 1'b0;
  int                  hold_cnt       = 0;

  int                  n_errors   = 0;
  int                  n_accepted = 0;
  int                  n_results  = 0;
  int                  n_hits     = 0;
  int                  n_evicts   = 0;
  int                  n_renders  = 0;

  shadow_slot_allocator_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_light_id         (in_light_id),
    .in_last_change_time (in_last_change_time),
    .in_now_time         (in_now_time),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_slot            (out_slot),
    .out_render_needed   (out_render_needed),
    .out_hit             (out_hit),
    .out_replaced        (out_replaced),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic bit roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // hit first, then lowest empty slot, then oldest render time (lowest index on ties)
  function automatic slot_res_t allocate_slot(input req_t r);
    int        n;
    int        pick;
    bit        found;
    slot_res_t res;
    n = (cfg_slots == 0) ? 1 :
        ((cfg_slots > ssa_pkg::SLOTS) ? ssa_pkg::SLOTS : int'(cfg_slots));
    pick = 0;
    found = 1'b0;
    res = '0;
    for (int i = 0; i < n && !found; i++)
      if (tbl_valid[i] && tbl_light[i] == r.light) begin
        pick = i;
        found = 1'b1;
        res.hit = 1'b1;
      end
    for (int i = 0; i < n && !found; i++)
      if (!tbl_valid[i]) begin
        pick = i;
        found = 1'b1;
      end
    if (!found) begin
      pick = 0;
      for (int i = 1; i < n; i++)
        if (tbl_time[i] < tbl_time[pick]) pick = i;
      res.replaced = 1'b1;
    end
    if (!res.hit) begin
      tbl_valid[pick] = 1'b1;
      tbl_light[pick] = r.light;
      tbl_time[pick]  = '0;
    end
    res.render = r.change >= tbl_time[pick];
    if (res.render) tbl_time[pick] = r.now;
    res.slot = pick[ssa_pkg::SLOT_W-1:0];
    return res;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   k;
    k = $urandom_range(99, 0);
    if (k < 10) begin
      // noise: any light, any times
      r.light  = ssa_pkg::TAG_W'($urandom);
      r.change = $urandom;
      r.now    = $urandom;
      return r;
    end
    time_base += $urandom_range(16, 0);
    r.light = light_pool[$urandom_range(POOL - 1, 0)];
    r.now   = time_base;
    if (k < 55)      r.change = time_base - $urandom_range(40, 0);
    else if (k < 75) r.change = time_base;
    else             r.change = time_base - $urandom_range(2000, 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("%0t ERROR %s: expected %0h got %0h", $time, what, want, got);
  endtask

  task automatic push_req(input logic [ssa_pkg::TAG_W-1:0] light,
                          input logic [ssa_pkg::TIME_W-1:0] change,
                          input logic [ssa_pkg::TIME_W-1:0] now);
    req_t r;
    r.light  = light;
    r.change = change;
    r.now    = now;
    pend_q.push_back(r);
  endtask

  task automatic write_slots(input logic [ssa_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_slots = v;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    @(posedge clk);
    send_idle_pct  <= (mode == IDLE_SEND) ? 88 : (mode == IDLE_BOTH) ? 10 : 0;
    recv_stall_pct <= (mode == IDLE_RECV) ? 88 : (mode == IDLE_BOTH) ? 10 : 0;
  endtask

  // block must be idle before any register write
  task automatic settle();
    @(negedge clk);
    while (pend_q.size() != 0 || in_valid || alloc_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : drive_blk
    bit fire;
    bit send;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        alloc_q.push_back(allocate_slot(cur_req));
        n_accepted++;
      end
      if (!in_valid || fire) begin
        send = pend_q.size() != 0 && !roll(send_idle_pct);
        if (send) begin
          cur_req = pend_q.pop_front();
          in_valid            <= 1'b1;
          in_light_id         <= cur_req.light;
          in_last_change_time <= cur_req.change;
          in_now_time         <= cur_req.now;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (hold_cnt == 0) && !hold_go && !roll(recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin : check_blk
    slot_res_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      n_hits    += out_hit;
      n_evicts  += out_replaced;
      n_renders += out_render_needed;
      if (alloc_q.size() == 0) begin
        report_mismatch("result beat with nothing expected", 0, out_slot);
      end else begin
        want = alloc_q.pop_front();
        if (out_slot !== want.slot) report_mismatch("slot", want.slot, out_slot);
        if (out_render_needed !== want.render)
          report_mismatch("render_needed", want.render, out_render_needed);
        if (out_hit !== want.hit) report_mismatch("hit", want.hit, out_hit);
        if (out_replaced !== want.replaced)
          report_mismatch("replaced", want.replaced, out_replaced);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t timeout: %0d results still outstanding", $time, alloc_q.size());
    $display("shadow_slot_allocator_unit regression: fail");
    $finish;
  end

  initial begin : sequencer
    logic [ssa_pkg::CFG_W-1:0] cfg_plan [RAND_PHASES];
    cfg_plan = '{4'd8, 4'd1, 4'd4, 4'd9, 4'd3, 4'd15, 4'd2, 4'd0, 4'd6, 4'd8, 4'd5, 4'd7};
    for (int i = 0; i < ssa_pkg::SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_light[i] = '0;
      tbl_time[i]  = '0;
    end
    light_pool[0] = 16'h0000;
    light_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL; i++) light_pool[i] = ssa_pkg::TAG_W'($urandom);
    time_base = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fill, hits with and without render, oldest-slot eviction with ties
    set_idle(IDLE_NONE);
    @(negedge clk);
    push_req(16'h0000, 32'h0, 32'h0);
    push_req(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 1; i <= 6; i++) push_req(i[ssa_pkg::TAG_W-1:0], 32'd50, 32'd100);
    push_req(16'hFFFF, 32'd5, 32'd300);
    push_req(16'h0000, 32'd0, 32'd7);
    push_req(16'h1234, 32'd0, 32'd200);
    push_req(16'h5555, 32'd1, 32'd150);
    settle();

    // zero count behaves as one slot; upper slots keep their contents
    write_slots(4'd0);
    @(negedge clk);
    push_req(16'hAAAA, 32'd10, 32'd400);
    push_req(16'hAAAA, 32'd400, 32'd410);
    push_req(16'h0002, 32'd0, 32'd420);
    settle();

    // count above table size behaves as full table; old entries hit again
    write_slots(4'd15);
    @(negedge clk);
    push_req(16'h0002, 32'd420, 32'd500);
    push_req(16'h0003, 32'd99, 32'd510);
    push_req(16'h0006, 32'd100, 32'd520);
    push_req(16'hAAAA, 32'h8000_0000, 32'd530);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_slots(cfg_plan[p]);
      set_idle(idle_mode_e'(p % 4));
      @(negedge clk);
      for (int i = 0; i < PHASE_ITEMS; i++) pend_q.push_back(random_request());
      if (p == 4) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      settle();
    end

    if (alloc_q.size() != 0) report_mismatch("results never delivered", 0, alloc_q.size());
    $display("covered %0d requests over %0d slot-count settings incl. 0, 1, 8 and 15",
             n_accepted, RAND_PHASES + 3);
    $display("results: %0d hits, %0d evictions, %0d renders, %0d mismatches",
             n_hits, n_evicts, n_renders, n_errors);
    if (n_errors == 0) $display("shadow_slot_allocator_unit regression: pass");
    else $display("shadow_slot_allocator_unit regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ssa_pkg.sv
rtl/ssa_cell.sv
rtl/shadow_slot_allocator_unit.sv
tb/shadow_slot_allocator_unit_tb.sv
